[rtl/superblock_crc_check_extract_macros.svh]
// Assertion helpers shared by the superblock checker.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef SUPERBLOCK_CRC_CHECK_EXTRACT_MACROS_SVH
`define SUPERBLOCK_CRC_CHECK_EXTRACT_MACROS_SVH

// Same-cycle implication.
`define SBCCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SBCCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sbcce_pkg.sv]
package sbcce_pkg;

  // Area geometry.
  localparam int unsigned SectorBytes = 512;
  localparam int unsigned AreaBytes   = SectorBytes * 16;
  localparam int unsigned Copy1Base   = SectorBytes;
  localparam int unsigned Copy2Base   = SectorBytes * 9;
  localparam int unsigned OffW        = $clog2(AreaBytes + 1);
  localparam int unsigned LocW        = $clog2(SectorBytes);

  // CRC32C, reflected form.
  localparam logic [31:0] CrcPoly = 32'h82F63B78;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  // Result word indices.
  localparam int unsigned IdxW = 4;
  typedef logic [IdxW-1:0] word_idx_t;
  localparam word_idx_t WordSectors  = 4'd0;
  localparam word_idx_t WordInitTime = 4'd1;
  localparam word_idx_t WordDevice0  = 4'd2;
  localparam word_idx_t WordPool0    = 4'd6;
  localparam word_idx_t WordLast     = 4'd9;

  typedef logic [63:0] word_t;

  // Captured fields of the chosen copy.
  typedef struct packed {
    logic [63:0]      sectors;
    logic [63:0]      init_time;
    logic [3:0][63:0] device_id;
    logic [3:0][63:0] pool_id;
  } sbcce_fields_t;

  // End-of-area event handed to the result sequencer.
  typedef struct packed {
    logic start;
    logic found;
    logic copy;
  } sbcce_done_t;

  // One byte of reflected CRC32C, bit by bit.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/superblock_crc_check_extract.sv]
// Throughput: one byte item per cycle unless stalled; the CRC32C byte update is combinational.
// The verdict is registered in the sequencer, then in the output register; ten result words,
// or one not-found item, follow one per cycle while the output side takes them.
// While results are being sent, bytes that reach sector 1 or later wait at the input register.
// Reset (rst_ni low, asynchronous) clears the offset, checksum, verdicts and both handshakes.
`include "superblock_crc_check_extract_macros.svh"

module superblock_crc_check_extract (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  logic        area_start_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        found_o,
  output logic        copy_used_o,
  output logic [3:0]  word_index_o,
  output logic [63:0] word_value_o,
  output logic        last_word_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);
  import sbcce_pkg::*;

  sbcce_done_t   done;
  sbcce_fields_t fields;
  logic          emit_busy;

  // Input register, checksum and field capture.
  sbcce_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_byte_i  (data_byte_i),
    .area_start_i (area_start_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .emit_busy_i  (emit_busy),
    .done_o       (done),
    .fields_o     (fields)
  );

  // Result sequencer and output register.
  sbcce_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .done_i       (done),
    .fields_i     (fields),
    .busy_o       (emit_busy),
    .found_o      (found_o),
    .copy_used_o  (copy_used_o),
    .word_index_o (word_index_o),
    .word_value_o (word_value_o),
    .last_word_o  (last_word_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

  // A run can only finish once the previous results have all been sent.
  `SBCCE_ASSERT_IMP(a_done_not_busy, done.start, !emit_busy, "run ended during emission")
  `SBCCE_ASSERT_NXT(a_done_starts, done.start, emit_busy, "emission did not start")
  `SBCCE_ASSERT_IMP(a_last_index, out_valid_o && last_word_o && found_o, word_index_o == WordLast, "last word has wrong index")
  `SBCCE_ASSERT_IMP(a_not_found, out_valid_o && !found_o, last_word_o && word_value_o == '0, "bad not-found result")

endmodule

[rtl/sbcce_core.sv]
module sbcce_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [7:0]              data_byte_i,
  input  logic                    area_start_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    emit_busy_i,
  output sbcce_pkg::sbcce_done_t  done_o,
  output sbcce_pkg::sbcce_fields_t fields_o
);
  import sbcce_pkg::*;

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_start_q;
  logic [OffW-1:0]   off_q, off_d;
  logic [31:0]       crc_q, crc_d;
  logic [31:0]       chk_q, chk_d;
  logic              ok1_q, ok1_d, ok2_q, ok2_d;
  logic [63:0]       sect_q, sect_d, init_q, init_d;
  logic [3:0][63:0]  dev_q, dev_d, pool_q, pool_d;

  logic [OffW-1:0]   eff_off;
  logic              in_area, in_copy1, in_copy2, capture, stall, go;
  logic [LocW-1:0]   loc;
  logic              ok1_eff, ok2_eff;
  logic [31:0]       crc_upd;
  logic [2:0]        lane;
  logic [5:0]        be_pos;

  // Offset decode for the item in the input register.
  always_comb begin
    eff_off  = in_start_q ? '0 : off_q;
    in_area  = eff_off < OffW'(AreaBytes);
    in_copy1 = (eff_off >= OffW'(Copy1Base)) && (eff_off < OffW'(Copy1Base + SectorBytes));
    in_copy2 = (eff_off >= OffW'(Copy2Base)) && (eff_off < OffW'(Copy2Base + SectorBytes));
    loc      = in_copy1 ? LocW'(eff_off - OffW'(Copy1Base))
                        : LocW'(eff_off - OffW'(Copy2Base));
    ok1_eff  = in_start_q ? 1'b0 : ok1_q;
    ok2_eff  = in_start_q ? 1'b0 : ok2_q;
    capture  = in_copy1 || !ok1_eff;
    // Hold back any item that could touch the captured fields while they are sent.
    stall    = emit_busy_i && (eff_off >= OffW'(Copy1Base));
    go       = in_valid_q && !stall;
    crc_upd  = crc_byte((loc == '0) ? CrcInit : crc_q, in_byte_q);
    be_pos   = {~loc[2:0], 3'b000};
  end

  assign in_ready_o = !in_valid_q || go;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q  <= data_byte_i;
      in_start_q <= area_start_i;
    end
  end

  // Per-item update of checksum, verdicts and captured fields.
  always_comb begin
    off_d  = off_q;
    crc_d  = crc_q;
    chk_d  = chk_q;
    ok1_d  = ok1_q;
    ok2_d  = ok2_q;
    sect_d = sect_q;
    init_d = init_q;
    dev_d  = dev_q;
    pool_d = pool_q;
    lane   = 3'(loc - LocW'(20));
    done_o = '0;
    if (go) begin
      ok1_d = ok1_eff;
      ok2_d = ok2_eff;
      if (in_start_q) begin
        crc_d = CrcInit;
        chk_d = '0;
      end
      if (in_area) begin
        if (in_copy1 || in_copy2) begin
          if (loc < LocW'(4)) begin
            chk_d = ((loc == '0) ? 32'b0 : chk_q) | ({24'b0, in_byte_q} << {loc[1:0], 3'b000});
            if (loc == '0) begin
              crc_d = CrcInit;
            end
          end else begin
            crc_d = crc_upd;
          end
          if (capture) begin
            if (loc >= LocW'(20) && loc < LocW'(28)) begin
              sect_d[{lane, 3'b000} +: 8] = in_byte_q;
            end else if (loc >= LocW'(120) && loc < LocW'(128)) begin
              init_d[{loc[2:0], 3'b000} +: 8] = in_byte_q;
            end else if (loc >= LocW'(32) && loc < LocW'(64)) begin
              pool_d[loc[4:3]][be_pos +: 8] = in_byte_q;
            end else if (loc >= LocW'(64) && loc < LocW'(96)) begin
              dev_d[loc[4:3]][be_pos +: 8] = in_byte_q;
            end
          end
          if (loc == LocW'(SectorBytes - 1)) begin
            if (in_copy2) begin
              ok2_d = ((crc_upd ^ CrcInit) == chk_q);
            end else begin
              ok1_d = ((crc_upd ^ CrcInit) == chk_q);
            end
          end
        end
        off_d = eff_off + OffW'(1);
        if (eff_off == OffW'(AreaBytes - 1)) begin
          done_o.start = 1'b1;
          done_o.found = ok1_d || ok2_d;
          done_o.copy  = !ok1_d;
        end
      end
    end
  end

  // Run state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= '0;
      crc_q  <= CrcInit;
      chk_q  <= '0;
      ok1_q  <= 1'b0;
      ok2_q  <= 1'b0;
      sect_q <= '0;
      init_q <= '0;
    end else begin
      off_q  <= off_d;
      crc_q  <= crc_d;
      chk_q  <= chk_d;
      ok1_q  <= ok1_d;
      ok2_q  <= ok2_d;
      sect_q <= sect_d;
      init_q <= init_d;
    end
  end

  // Identifier words are always written before they are read.
  always_ff @(posedge clk_i) begin
    dev_q  <= dev_d;
    pool_q <= pool_d;
  end

  assign fields_o.sectors   = sect_q;
  assign fields_o.init_time = init_q;
  assign fields_o.device_id = dev_q;
  assign fields_o.pool_id   = pool_q;

endmodule

[rtl/sbcce_emit.sv]
module sbcce_emit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sbcce_pkg::sbcce_done_t   done_i,
  input  sbcce_pkg::sbcce_fields_t fields_i,
  output logic                     busy_o,
  output logic                     found_o,
  output logic                     copy_used_o,
  output logic [3:0]               word_index_o,
  output logic [63:0]              word_value_o,
  output logic                     last_word_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i
);
  import sbcce_pkg::*;

  logic       busy_q, busy_d;
  word_idx_t  idx_q, idx_d;
  logic       found_q, found_d, copy_q, copy_d;
  logic       out_valid_q, out_valid_d;
  logic       out_found_q, out_found_d, out_copy_q, out_copy_d, out_last_q, out_last_d;
  word_idx_t  out_idx_q, out_idx_d;
  word_t      out_word_q, out_word_d;
  word_t      sel_word;
  logic       load;

  // Word selection for the current index.
  always_comb begin
    if (idx_q == WordSectors) begin
      sel_word = fields_i.sectors;
    end else if (idx_q == WordInitTime) begin
      sel_word = fields_i.init_time;
    end else if (idx_q < WordPool0) begin
      sel_word = fields_i.device_id[2'(idx_q - WordDevice0)];
    end else begin
      sel_word = fields_i.pool_id[2'(idx_q - WordPool0)];
    end
  end

  // Sequencer and output register.
  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    found_d     = found_q;
    copy_d      = copy_q;
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_copy_d  = out_copy_q;
    out_idx_d   = out_idx_q;
    out_word_d  = out_word_q;
    out_last_d  = out_last_q;
    load        = busy_q && (!out_valid_q || out_ready_i);
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      if (!found_q) begin
        out_found_d = 1'b0;
        out_copy_d  = 1'b0;
        out_idx_d   = WordSectors;
        out_word_d  = '0;
        out_last_d  = 1'b1;
        busy_d      = 1'b0;
      end else begin
        out_found_d = 1'b1;
        out_copy_d  = copy_q;
        out_idx_d   = idx_q;
        out_word_d  = sel_word;
        out_last_d  = (idx_q == WordLast);
        busy_d      = (idx_q != WordLast);
        idx_d       = idx_q + word_idx_t'(1);
      end
    end
    if (done_i.start) begin
      busy_d  = 1'b1;
      idx_d   = WordSectors;
      found_d = done_i.found;
      copy_d  = done_i.copy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= WordSectors;
      found_q     <= 1'b0;
      copy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      copy_q      <= copy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
    out_copy_q  <= out_copy_d;
    out_idx_q   <= out_idx_d;
    out_word_q  <= out_word_d;
    out_last_q  <= out_last_d;
  end

  assign busy_o       = busy_q;
  assign out_valid_o  = out_valid_q;
  assign found_o      = out_found_q;
  assign copy_used_o  = out_copy_q;
  assign word_index_o = out_idx_q;
  assign word_value_o = out_word_q;
  assign last_word_o  = out_last_q;

endmodule

[test/superblock_crc_check_extract_tb.sv]
module superblock_crc_check_extract_tb;
  import sbcce_pkg::*;

  // Layout of one superblock copy, as byte offsets within its sector.
  localparam int unsigned SumBytes   = 4;
  localparam int unsigned SectorsAt  = 20;
  localparam int unsigned PoolAt     = 32;
  localparam int unsigned DeviceAt   = 64;
  localparam int unsigned InitTimeAt = 120;

  typedef enum int {
    FillZero,
    FillOnes,
    FillRandom
  } fill_e;

  // One result item as the block should present it.
  typedef struct packed {
    logic      found;
    logic      copy;
    word_idx_t idx;
    word_t     val;
    logic      last;
  } sb_word_t;

  // One area to stream: an optional aborted run first, then a full area, then ignored bytes.
  typedef struct packed {
    bit          restart;
    fill_e       fill;
    bit          good1;
    bit          good2;
    int unsigned cut;
    int unsigned tail;
    bit          typed_miss;
  } area_case_t;

  localparam sb_word_t NotFoundWord = '{1'b0, 1'b0, WordSectors, 64'd0, 1'b1};

  // Directed areas. Rows with typed_miss set expect the single not-found item.
  area_case_t plan [6] = '{
    '{1'b0, FillZero,   1'b1, 1'b1, 0,    3, 1'b0}, // first byte after reset is byte 0
    '{1'b1, FillOnes,   1'b0, 1'b1, 0,    0, 1'b0}, // fall back to the second copy
    '{1'b1, FillRandom, 1'b0, 1'b0, 1500, 0, 1'b1}, // restart clears a good first verdict
    '{1'b1, FillRandom, 1'b1, 1'b0, 0,    0, 1'b0}, // first copy only
    '{1'b1, FillRandom, 1'b0, 1'b0, 0,    5, 1'b1}, // neither copy passes
    '{1'b1, FillRandom, 1'b1, 1'b1, 4800, 2, 1'b0}  // restart in the middle of the second copy
  };

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic [7:0]  data_byte_i  = 8'd0;
  logic        area_start_i = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic        found_o;
  logic        copy_used_o;
  logic [3:0]  word_index_o;
  logic [63:0] word_value_o;
  logic        last_word_o;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;

  // Tracked state of the checker.
  int unsigned area_pos      = 0;
  logic [31:0] run_crc       = CrcInit;
  logic [31:0] held_sum      = 32'd0;
  bit          copy1_ok      = 1'b0;
  bit          copy2_ok      = 1'b0;
  word_t       cap_sectors   = '0;
  word_t       cap_init_time = '0;
  logic [7:0]  cap_device [32];
  logic [7:0]  cap_pool [32];

  logic [7:0]  area_img [AreaBytes];
  sb_word_t    fresh_words [$];
  sb_word_t    pending_words [$];
  bit          typed_miss    = 1'b0;
  bit          calm          = 1'b0;
  int unsigned items_sent    = 0;
  int unsigned ready_hold    = 0;
  int unsigned mismatches    = 0;

  superblock_crc_check_extract dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_byte_i  (data_byte_i),
    .area_start_i (area_start_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .found_o      (found_o),
    .copy_used_o  (copy_used_o),
    .word_index_o (word_index_o),
    .word_value_o (word_value_o),
    .last_word_o  (last_word_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

  // Clock with a period of four units.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Reflected CRC32C over one byte, taking the data bits one at a time.
  function automatic logic [31:0] crc32c_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c = c >> 1;
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  // Mostly no pause, sometimes a short one, rarely a long one; none in calm stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Follows one byte of a superblock copy.
  function automatic void track_copy_byte(int unsigned loc, bit second, logic [7:0] b);
    bit grab;
    grab = !second || !copy1_ok;
    if (loc == 0) begin
      run_crc  = CrcInit;
      held_sum = 32'd0;
    end
    if (loc < SumBytes) held_sum[8*loc +: 8] = b;
    else run_crc = crc32c_step(run_crc, b);
    // Fields are taken from the first copy, and from the second only if the first failed.
    if (grab) begin
      if (loc >= SectorsAt && loc < SectorsAt + 8) begin
        cap_sectors[8*(loc-SectorsAt) +: 8] = b;
      end else if (loc >= InitTimeAt && loc < InitTimeAt + 8) begin
        cap_init_time[8*(loc-InitTimeAt) +: 8] = b;
      end else if (loc >= PoolAt && loc < PoolAt + 32) begin
        cap_pool[loc-PoolAt] = b;
      end else if (loc >= DeviceAt && loc < DeviceAt + 32) begin
        cap_device[loc-DeviceAt] = b;
      end
    end
    if (loc == SectorBytes - 1) begin
      if (second) copy2_ok = (~run_crc == held_sum);
      else copy1_ok = (~run_crc == held_sum);
    end
  endfunction

  // Follows one accepted item and leaves any result items in fresh_words.
  function automatic void track_area_byte(logic [7:0] b, bit st);
    int unsigned at;
    sb_word_t    w;
    word_t       acc;
    if (st) begin
      area_pos = 0;
      copy1_ok = 1'b0;
      copy2_ok = 1'b0;
      run_crc  = CrcInit;
      held_sum = 32'd0;
    end
    // Past the end of the area, bytes are ignored.
    if (area_pos >= AreaBytes) return;
    at = area_pos;
    if (at >= Copy1Base && at < Copy1Base + SectorBytes) begin
      track_copy_byte(at - Copy1Base, 1'b0, b);
    end else if (at >= Copy2Base && at < Copy2Base + SectorBytes) begin
      track_copy_byte(at - Copy2Base, 1'b1, b);
    end
    area_pos = at + 1;
    if (at != AreaBytes - 1) return;
    if (!copy1_ok && !copy2_ok) begin
      fresh_words.push_back(NotFoundWord);
      return;
    end
    w.found = 1'b1;
    w.copy  = !copy1_ok;
    w.last  = 1'b0;
    w.idx   = WordSectors;
    w.val   = cap_sectors;
    fresh_words.push_back(w);
    w.idx   = WordInitTime;
    w.val   = cap_init_time;
    fresh_words.push_back(w);
    // Identifier words: four of the device id, then four of the pool id, first byte on top.
    for (int k = 0; k < 8; k++) begin
      acc = '0;
      for (int j = 0; j < 8; j++) begin
        acc = {acc[55:0], (k < 4) ? cap_device[8*k+j] : cap_pool[8*(k-4)+j]};
      end
      w.idx  = word_idx_t'(WordDevice0 + k);
      w.val  = acc;
      w.last = (w.idx == WordLast);
      fresh_words.push_back(w);
    end
  endfunction

  // Writes the checksum of one copy, correct or with one bit flipped.
  function automatic void seal_copy(int unsigned base, bit good);
    logic [31:0] c;
    c = CrcInit;
    for (int i = SumBytes; i < SectorBytes; i++) c = crc32c_step(c, area_img[base+i]);
    c = ~c;
    if (!good) c = c ^ (32'd1 << $urandom_range(0, 31));
    for (int i = 0; i < SumBytes; i++) area_img[base+i] = c[8*i +: 8];
  endfunction

  function automatic void build_area(fill_e fill, bit good1, bit good2);
    for (int i = 0; i < AreaBytes; i++) begin
      case (fill)
        FillZero: area_img[i] = 8'h00;
        FillOnes: area_img[i] = 8'hFF;
        default:  area_img[i] = 8'($urandom);
      endcase
    end
    seal_copy(Copy1Base, good1);
    seal_copy(Copy2Base, good2);
  endfunction

  // Offers one item, waits for it to be taken and queues what it should cause.
  task automatic put_byte(input logic [7:0] b, input bit st);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    data_byte_i  <= b;
    area_start_i <= st;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    track_area_byte(b, st);
    if (fresh_words.size() > 0) begin
      if (typed_miss) begin
        pending_words.push_back(NotFoundWord);
      end else begin
        foreach (fresh_words[k]) pending_words.push_back(fresh_words[k]);
      end
      fresh_words.delete();
    end
    items_sent++;
    if (items_sent % 1024 == 0) calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic run_area(input area_case_t c);
    if (c.cut > 0) begin
      build_area(FillRandom, 1'b1, 1'b1);
      for (int i = 0; i < c.cut; i++) put_byte(area_img[i], i == 0);
    end
    build_area(c.fill, c.good1, c.good2);
    typed_miss = c.typed_miss;
    for (int i = 0; i < AreaBytes; i++) put_byte(area_img[i], c.restart && i == 0);
    typed_miss = 1'b0;
    for (int i = 0; i < c.tail; i++) put_byte(8'($urandom), 1'b0);
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 200) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
    end
  endfunction

  // Result side: compare each taken item with the oldest expectation, and stall at random.
  always @(posedge clk_i) begin
    sb_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 200) begin
          $display("%0t: unexpected item, expected none, got index %0d value %0h",
                   $time, word_index_o, word_value_o);
        end
      end else begin
        want = pending_words.pop_front();
        check_field("found", 64'(want.found), 64'(found_o));
        check_field("copy_used", 64'(want.copy), 64'(copy_used_o));
        check_field("word_index", 64'(want.idx), 64'(word_index_o));
        check_field("word_value", want.val, word_value_o);
        check_field("last_word", 64'(want.last), 64'(last_word_o));
      end
    end
    if (ready_hold > 0) begin
      out_ready_i <= 1'b0;
      ready_hold--;
    end else begin
      out_ready_i <= 1'b1;
      ready_hold = pick_gap();
    end
  end

  // Stimulus: directed areas, then random areas until enough items have been sent.
  initial begin
    area_case_t  rc;
    int unsigned base_items;
    int unsigned r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[p]) run_area(plan[p]);
    base_items = items_sent;
    while (items_sent - base_items < 230) begin
      r = $urandom_range(0, 9);
      rc.restart    = 1'b1;
      rc.fill       = (r == 0) ? FillZero : (r == 1) ? FillOnes : FillRandom;
      rc.good1      = ($urandom_range(0, 3) != 0);
      rc.good2      = ($urandom_range(0, 3) != 0);
      rc.cut        = ($urandom_range(0, 4) == 0) ? $urandom_range(1, AreaBytes - 1) : 0;
      rc.tail       = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
      rc.typed_miss = 1'b0;
      run_area(rc);
    end
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #(64'd80_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/sbcce_pkg.sv
rtl/sbcce_core.sv
rtl/sbcce_emit.sv
rtl/superblock_crc_check_extract.sv
test/superblock_crc_check_extract_tb.sv
